### rtl/core/psv_pkg.sv
// ----------------------------------------------------------------------------
// psv_pkg
// Shared types and constants for the pipelined prime sieve.
// ----------------------------------------------------------------------------
package psv_pkg;

  // Width of the value and prime fields on the ports
  localparam int unsigned WORD_W = 16;

  // Result status codes
  localparam logic STATUS_NEW       = 1'b0;
  localparam logic STATUS_UNDECIDED = 1'b1;

  // One bit of a candidate travelling down the chain, MSB first.
  // alive and claimed only carry meaning on the last bit.
  typedef struct packed {
    logic valid;
    logic dat;
    logic first;
    logic last;
    logic eos;
    logic alive;
    logic claimed;
  } psv_token_t;

endpackage

### rtl/core/psv_in_if.sv
// ----------------------------------------------------------------------------
// psv_in_if
// Candidate word channel: valid/ready handshake with value and end flag.
// ----------------------------------------------------------------------------
interface psv_in_if
  import psv_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] value;
  logic              end_of_stream;

  modport source (output valid, output value, output end_of_stream, input ready);
  modport sink   (input valid, input value, input end_of_stream, output ready);
endinterface

### rtl/core/psv_out_if.sv
// ----------------------------------------------------------------------------
// psv_out_if
// Result word channel: valid/ready handshake with prime and status.
// ----------------------------------------------------------------------------
interface psv_out_if
  import psv_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] prime;
  logic              status;

  modport source (output valid, output prime, output status, input ready);
  modport sink   (input valid, input prime, input status, output ready);
endinterface

### rtl/core/psv_cell.sv
// ----------------------------------------------------------------------------
// psv_cell
// One sieve stage. Keeps a running remainder of the bit-serial candidate
// against its prime; an empty stage shifts the candidate in as its prime.
// ----------------------------------------------------------------------------
module psv_cell
  import psv_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  psv_token_t tok_i,
  output psv_token_t tok_o
);

  logic                  used_q, used_d;
  logic [VALUE_BITS-1:0] prime_q, prime_d;
  logic [VALUE_BITS-1:0] rem_q, rem_d;
  logic [VALUE_BITS-1:0] rem_base;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   prime_ext;
  logic                  divides;
  psv_token_t            tok_q, tok_d;

  // r <- (2r + bit) mod p; with r < p one conditional subtract suffices
  always_comb begin
    rem_base  = tok_i.first ? '0 : rem_q;
    trial     = {rem_base, tok_i.dat};
    prime_ext = {1'b0, prime_q};
    if (trial >= prime_ext) begin
      rem_d = VALUE_BITS'(trial - prime_ext);
    end else begin
      rem_d = VALUE_BITS'(trial);
    end
    // a stage holding zero never divides
    divides = used_q && (prime_q != '0) && (rem_d == '0);
  end

  always_comb begin
    tok_d         = tok_i;
    tok_d.alive   = tok_i.alive & used_q & ~divides;
    tok_d.claimed = tok_i.claimed | (tok_i.alive & ~used_q);

    used_d  = used_q;
    prime_d = prime_q;
    if (tok_i.valid && !used_q) begin
      prime_d = {prime_q[VALUE_BITS-2:0], tok_i.dat};
    end
    if (tok_i.valid && tok_i.last) begin
      if (tok_i.eos) begin
        used_d = 1'b0;
      end else if (tok_i.alive && !used_q) begin
        used_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      tok_q  <= '0;
    end else begin
      used_q <= used_d;
      tok_q  <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prime_q <= prime_d;
    if (tok_i.valid) begin
      rem_q <= rem_d;
    end
  end

  assign tok_o = tok_q;

endmodule

### rtl/core/pipelined_prime_sieve.sv
// ----------------------------------------------------------------------------
// pipelined_prime_sieve
// Prime sieve as a row of stages; each candidate walks the row bit-serially.
// A result passes a pending register, then the output register, once the last
// bit leaves the final stage. One word at a time: a dropped word frees the input
// as its last bit leaves, a result word when loaded out (later if output held).
// Reset clears all stages at once; stage primes are not reset.
// ----------------------------------------------------------------------------
module pipelined_prime_sieve
  import psv_pkg::*;
#(
  parameter int unsigned MAX_STAGES = 32,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  psv_in_if.sink  in_i,
  psv_out_if.source out_o
);

  localparam int unsigned IDX_W = $clog2(VALUE_BITS);

  psv_token_t tok [MAX_STAGES+1];

  logic                  busy_q, busy_d;
  logic                  feeding_q, feeding_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [VALUE_BITS-1:0] n_q, n_d;
  logic                  eos_q, eos_d;
  logic                  pend_q, pend_d;
  logic                  pend_status_q, pend_status_d;
  logic                  out_valid_q, out_valid_d;
  logic [WORD_W-1:0]     out_prime_q, out_prime_d;
  logic                  out_status_q, out_status_d;
  logic                  accept;
  logic                  load_out;
  psv_token_t            tok_end;

  assign in_i.ready = ~busy_q;
  assign accept     = in_i.valid & ~busy_q;

  // bit stream into the first stage, MSB first
  always_comb begin
    tok[0].valid   = feeding_q;
    tok[0].dat     = n_q[idx_q];
    tok[0].first   = (idx_q == IDX_W'(VALUE_BITS - 1));
    tok[0].last    = (idx_q == '0);
    tok[0].eos     = eos_q;
    tok[0].alive   = 1'b1;
    tok[0].claimed = 1'b0;
  end

  for (genvar k = 0; k < MAX_STAGES; k++) begin : g_cell
    psv_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (tok[k]),
      .tok_o (tok[k+1])
    );
  end

  assign tok_end  = tok[MAX_STAGES];
  assign load_out = pend_q & (~out_valid_q | out_o.ready);

  always_comb begin
    busy_d        = busy_q;
    feeding_d     = feeding_q;
    idx_d         = idx_q;
    n_d           = n_q;
    eos_d         = eos_q;
    pend_d        = pend_q;
    pend_status_d = pend_status_q;
    out_valid_d   = out_valid_q;
    out_prime_d   = out_prime_q;
    out_status_d  = out_status_q;

    if (accept) begin
      busy_d    = 1'b1;
      feeding_d = 1'b1;
      idx_d     = IDX_W'(VALUE_BITS - 1);
      n_d       = VALUE_BITS'(in_i.value);
      eos_d     = in_i.end_of_stream;
    end else if (feeding_q) begin
      if (idx_q == '0) begin
        feeding_d = 1'b0;
      end else begin
        idx_d = idx_q - IDX_W'(1);
      end
    end

    // last bit leaves the final stage: word claimed, undecided or dropped
    if (tok_end.valid && tok_end.last) begin
      if (tok_end.claimed || tok_end.alive) begin
        pend_d        = 1'b1;
        pend_status_d = tok_end.claimed ? STATUS_NEW : STATUS_UNDECIDED;
      end else begin
        busy_d = 1'b0;
      end
    end

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d  = 1'b1;
      out_prime_d  = WORD_W'(n_q);
      out_status_d = pend_status_q;
      pend_d       = 1'b0;
      busy_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      feeding_q   <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      feeding_q   <= feeding_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q         <= idx_d;
    n_q           <= n_d;
    eos_q         <= eos_d;
    pend_status_q <= pend_status_d;
    out_prime_q   <= out_prime_d;
    out_status_q  <= out_status_d;
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.prime  = out_prime_q;
  assign out_o.status = out_status_q;

endmodule
